// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the calendar date blocks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that an expression never holds outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ===== rtl/cdadv_pkg.sv =====
// Types, constants and calendar helper functions for the date advance block
`timescale 1ns / 1ps
package cdadv_pkg;

    localparam int DAY_COUNT_BITS = 16;

    localparam logic [13:0] MAX_YEAR    = 14'd9999;
    localparam logic [13:0] RESET_YEAR  = 14'd2000;
    localparam logic [3:0]  RESET_MONTH = 4'd1;
    localparam logic [4:0]  RESET_DAY   = 5'd1;
    // 1 January 2000 is a Saturday
    localparam logic [2:0]  RESET_WDAY  = 3'd6;
    localparam logic [2:0]  LAST_WDAY   = 3'd6;
    localparam logic [3:0]  FEB         = 4'd2;
    localparam logic [3:0]  DEC         = 4'd12;
    localparam logic [4:0]  DEC_LAST    = 5'd31;
    // floor(x / 25) == (x * 1311) >> 15 for x below 4096
    localparam logic [22:0] RECIP_25    = 23'd1311;

    typedef enum logic [1:0] {
        STATUS_OK,
        STATUS_BAD_LOAD,
        STATUS_SATURATED
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_WSUM,
        S_WDAY,
        S_STEP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic        func;
        logic [3:0]  set_month;
        logic [4:0]  set_day;
        logic [13:0] set_year;
        logic [15:0] day_count;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  cur_month;
        logic [4:0]  cur_day;
        logic [13:0] cur_year;
        logic [2:0]  weekday;
        logic        leap_flag;
        logic [1:0]  status;
    } t_out_item;

    typedef struct packed {
        logic    capture;
        logic    commit;
        logic    wsum;
        logic    wday;
        logic    step;
        logic    res_write;
        t_status res_status;
    } t_dp_cmd;

    typedef struct packed {
        logic func;
        logic load_ok;
        logic count_zero;
        logic at_max;
    } t_dp_sts;

    // Gregorian leap rule without a divider
    function automatic logic is_leap(input logic [13:0] y);
        logic [11:0] u;
        logic [22:0] prod;
        logic [7:0]  q;
        logic [11:0] rem;
        u    = y[13:2];
        prod = {11'b0, u} * RECIP_25;
        q    = prod[22:15];
        rem  = u - ({4'b0, q} * 12'd25);
        return (y[1:0] == 2'b00) && ((rem != 12'd0) || (q[1:0] == 2'b00));
    endfunction

    // Length of a month; zero for a month code outside 1..12
    function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd2:                         len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:      len = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7,
            4'd8, 4'd10, 4'd12:           len = 5'd31;
            default:                      len = 5'd0;
        endcase
        return len;
    endfunction

    // Days in the year before the first of a month, common year
    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] n;
        case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

    // Sum congruent mod 7 to the weekday of a valid date (365 = 1 mod 7)
    function automatic logic [13:0] weekday_sum(input logic [3:0] m, input logic [4:0] d,
                                                input logic [13:0] y, input logic leap);
        logic [13:0] p;
        logic [11:0] t;
        logic [22:0] prod;
        logic [7:0]  h;
        logic [5:0]  f;
        p    = y - 14'd1;
        t    = p[13:2];
        prod = {11'b0, t} * RECIP_25;
        h    = prod[22:15];
        f    = h[7:2];
        return p + {2'b0, t} - {6'b0, h} + {8'b0, f} + {5'b0, days_before(m)}
               + {9'b0, d} + {13'b0, (m > FEB) && leap};
    endfunction

    // Remainder by 7 through octal digit folding (8 = 1 mod 7)
    function automatic logic [2:0] mod7(input logic [13:0] s);
        logic [5:0] s1;
        logic [3:0] s2;
        logic [3:0] s3;
        s1 = {3'b0, s[2:0]} + {3'b0, s[5:3]} + {3'b0, s[8:6]} + {3'b0, s[11:9]}
             + {4'b0, s[13:12]};
        s2 = {1'b0, s1[2:0]} + {1'b0, s1[5:3]};
        s3 = {1'b0, s2[2:0]} + {3'b0, s2[3]};
        return (s3 >= 4'd7) ? 3'(s3 - 4'd7) : s3[2:0];
    endfunction

endpackage

// ===== rtl/cdadv_dp.sv =====
// Datapath: held date, weekday, day counter, load check and result register
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cdadv_dp
    import cdadv_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    output t_out_item o_res
);

    logic [3:0]                r_month;
    logic [4:0]                r_day;
    logic [13:0]               r_year;
    logic [2:0]                r_wday;
    logic [DAY_COUNT_BITS-1:0] r_count;
    logic [13:0]               r_wsum;
    t_in_item                  r_set;
    t_out_item                 r_res;

    logic       w_leap;
    logic [4:0] w_dim;
    logic       w_set_leap;
    logic       w_at_max;
    logic       w_load_ok;

    // Calendar facts of the held date
    assign w_leap   = is_leap(r_year);
    assign w_dim    = days_in_month(r_month, w_leap);
    assign w_at_max = (r_month == DEC) && (r_day == DEC_LAST) && (r_year == MAX_YEAR);

    // Validate the captured load date
    assign w_set_leap = is_leap(r_set.set_year);
    assign w_load_ok  = (r_set.set_year >= 14'd1) && (r_set.set_year <= MAX_YEAR)
                      && (r_set.set_day >= 5'd1)
                      && (r_set.set_day <= days_in_month(r_set.set_month, w_set_leap));

    assign o_sts.func       = r_set.func;
    assign o_sts.load_ok    = w_load_ok;
    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.at_max     = w_at_max;
    assign o_res            = r_res;

    // Held date and weekday: load, set the weekday from the sum, or advance one day
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_month <= RESET_MONTH;
            r_day   <= RESET_DAY;
            r_year  <= RESET_YEAR;
            r_wday  <= RESET_WDAY;
        end else if (i_cmd.commit) begin
            r_month <= r_set.set_month;
            r_day   <= r_set.set_day;
            r_year  <= r_set.set_year;
        end else if (i_cmd.wday) begin
            r_wday <= mod7(r_wsum);
        end else if (i_cmd.step) begin
            r_wday <= (r_wday == LAST_WDAY) ? 3'd0 : r_wday + 3'd1;
            if (r_day < w_dim) begin
                r_day <= r_day + 5'd1;
            end else begin
                r_day <= 5'd1;
                if (r_month == DEC) begin
                    r_month <= 4'd1;
                    r_year  <= r_year + 14'd1;
                end else begin
                    r_month <= r_month + 4'd1;
                end
            end
        end
    end

    // Capture the item, count down days, form the weekday sum
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_set   <= i_in;
            r_count <= i_in.day_count[DAY_COUNT_BITS-1:0];
        end else if (i_cmd.step) begin
            r_count <= r_count - DAY_COUNT_BITS'(1);
        end
        if (i_cmd.wsum) begin
            r_wsum <= weekday_sum(r_month, r_day, r_year, w_leap);
        end
    end

    // Latch the result for transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_write) begin
            r_res.cur_month <= r_month;
            r_res.cur_day   <= r_day;
            r_res.cur_year  <= r_year;
            r_res.weekday   <= r_wday;
            r_res.leap_flag <= w_leap;
            r_res.status    <= i_cmd.res_status;
        end
    end

    `ASSERT_CLK(a_date_valid, i_clk, i_rst_n, (r_month >= 4'd1) && (r_day >= 5'd1) && (r_day <= w_dim) && (r_year >= 14'd1) && (r_year <= MAX_YEAR), "held date is not a valid calendar date")
    `ASSERT_NEVER(a_step_past_max, i_clk, i_rst_n, i_cmd.step && w_at_max, "advance stepped past the last date")

endmodule

// ===== rtl/cdadv_ctrl.sv =====
// Controller: sequences load, weekday computation, day stepping and result transfer
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cdadv_ctrl
    import cdadv_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_stall,
    input  t_dp_sts i_sts,
    output logic    o_in_stall,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    t_state  r_state;
    t_state  n_state;
    t_status r_status;
    t_status n_status;
    logic    r_out_valid;
    logic    n_out_valid;

    // State, status and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_status    <= STATUS_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state          = r_state;
        n_status         = r_status;
        o_cmd            = '0;
        o_cmd.res_status = r_status;
        o_in_stall       = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_status      = STATUS_OK;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.func) begin
                    n_state = S_STEP;
                end else if (i_sts.load_ok) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_WSUM;
                end else begin
                    n_status = STATUS_BAD_LOAD;
                    n_state  = S_DONE;
                end
            end
            S_WSUM: begin
                o_cmd.wsum = 1'b1;
                n_state    = S_WDAY;
            end
            S_WDAY: begin
                o_cmd.wday = 1'b1;
                n_state    = S_DONE;
            end
            S_STEP: begin
                if (i_sts.count_zero) begin
                    n_state = S_DONE;
                end else if (i_sts.at_max) begin
                    n_status = STATUS_SATURATED;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.res_write = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Raise valid on a new result, drop it after the transfer
    always_comb begin
        if (o_cmd.res_write) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `ASSERT_CLK(a_res_slot_free, i_clk, i_rst_n, o_cmd.res_write |-> (!r_out_valid || !i_out_stall), "result written over a waiting result")
    `ASSERT_CLK(a_accept_to_check, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> (r_state == S_CHECK), "accepted item did not enter the check step")

endmodule

// ===== rtl/calendar_date_advance.sv =====
// Top level of the Gregorian date register with load and day advance
`timescale 1ns / 1ps
// Holds a Gregorian date (reset 1 January 2000, a Saturday) and handles one
// item at a time. A load steps through check and commit, weekday sum,
// remainder by 7 and result write, and then the output transfer; a rejected
// load goes from the check straight to the result write and the transfer.
// An advance by N days checks the item, steps the held date one day at a
// time while the day counter counts down, sees the counter at zero, writes
// the result and then transfers. Past 31 December 9999 it stops early and
// reports saturation. A result that finds the previous one still stalled in
// the output register waits in the done step until that one transfers. A new
// item is accepted as soon as the previous result is in the output register,
// even while that result waits.
module calendar_date_advance
    import cdadv_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequence the work
    cdadv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    // Hold and advance the date
    cdadv_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in_data),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_res   (o_out_data)
    );

endmodule
